### rtl/core/stepper_position_stepper_with_limits_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepper position controller
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_POSITION_STEPPER_WITH_LIMITS_ASSERT_SVH
`define STEPPER_POSITION_STEPPER_WITH_LIMITS_ASSERT_SVH

// Same-cycle implication
`define SPSWL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPSWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/spswl_pkg.sv
// ----------------------------------------------------------------------------
// spswl_pkg
// Shared types and constants of the stepper position controller.
// ----------------------------------------------------------------------------
package spswl_pkg;

    localparam int POS_WIDTH_DEFAULT = 32;
    localparam int FIELD_WIDTH       = 32;
    localparam int CMD_WIDTH         = 4;
    localparam int CFG_INDEX_WIDTH   = 8;

    localparam logic PIN_LOW  = 1'b0;
    localparam logic PIN_HIGH = 1'b1;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK     = 4'd0,
        CMD_MOVE_TO  = 4'd1,
        CMD_GO_MIN   = 4'd2,
        CMD_GO_MAX   = 4'd3,
        CMD_GO_ZERO  = 4'd4,
        CMD_SET_ZERO = 4'd5,
        CMD_STOP     = 4'd6,
        CMD_ENABLE   = 4'd7,
        CMD_DISABLE  = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_REACHED = 2'd0,
        ST_MOVING  = 2'd1,
        ST_AT_MIN  = 2'd2,
        ST_AT_MAX  = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_LIMIT   = 8'd0,
        CFG_MAX_LIMIT   = 8'd1,
        CFG_INVERT_DIR  = 8'd2,
        CFG_ENABLE_GATE = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic    step_phase;
        logic    step_pin;
        logic    heading_back;
        logic    enabled;
        status_t status;
    } ctrl_t;

endpackage

### rtl/core/stepper_position_stepper_with_limits.sv
// ----------------------------------------------------------------------------
// stepper_position_stepper_with_limits
// Stepper position controller with soft limits, one result per request.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | command, new_target
//  out      | out_valid / out_stall| position, target_position, step_level,
//           |                      | dir_level, status, moved
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One request per cycle unless stalled; a request passes the input register, then the result register.
//  The next-state logic (one add and parallel compares) sits between them.
//  Reset clears position, target, step pin, status, enable flag and all limits.
//  A stalled result holds, and the state with it; one more request waits in
//  the input register before in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
module stepper_position_stepper_with_limits
    import spswl_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [CMD_WIDTH-1:0]        command,
    input  logic signed [FIELD_WIDTH-1:0] new_target,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [FIELD_WIDTH-1:0] position,
    output logic signed [FIELD_WIDTH-1:0] target_position,
    output logic                        step_level,
    output logic                        dir_level,
    output logic [1:0]                  status,
    output logic                        moved,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [FIELD_WIDTH-1:0]      cfg_data
);

    logic                        in_valid_reg;
    logic [CMD_WIDTH-1:0]        cmd_reg;
    logic [FIELD_WIDTH-1:0]      tgt_reg;
    logic                        out_valid_reg;
    logic                        moved_reg;
    logic                        dir_reg;
    logic signed [POS_WIDTH-1:0] pos_reg;
    logic signed [POS_WIDTH-1:0] goal_reg;
    ctrl_t                       ctrl_reg;
    logic signed [POS_WIDTH-1:0] min_reg;
    logic signed [POS_WIDTH-1:0] max_reg;
    logic                        invert_reg;
    logic                        gate_reg;

    logic signed [POS_WIDTH-1:0] pos_next;
    logic signed [POS_WIDTH-1:0] goal_next;
    ctrl_t                       ctrl_next;
    logic                        moved_next;
    logic                        advance;
    logic                        in_fire;
    logic                        cfg_fire;
    cfg_index_t                  cfg_sel;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_sel   = cfg_index_t'(cfg_index);

    spswl_step_unit #(
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .command         (cmd_reg),
        .new_target      (tgt_reg),
        .pos             (pos_reg),
        .goal            (goal_reg),
        .ctrl            (ctrl_reg),
        .min_limit       (min_reg),
        .max_limit       (max_reg),
        .use_enable_gate (gate_reg),
        .pos_next        (pos_next),
        .goal_next       (goal_next),
        .ctrl_next       (ctrl_next),
        .step_made       (moved_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= command;
            tgt_reg <= new_target;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            goal_reg      <= '0;
            ctrl_reg      <= '{step_phase: 1'b0, step_pin: PIN_LOW, heading_back: 1'b0,
                               enabled: 1'b0, status: ST_REACHED};
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                goal_reg      <= goal_next;
                ctrl_reg      <= ctrl_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            moved_reg <= moved_next;
            dir_reg   <= ctrl_next.heading_back ^ invert_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            max_reg    <= '0;
            invert_reg <= 1'b0;
            gate_reg   <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_sel)
                CFG_MIN_LIMIT:   min_reg    <= POS_WIDTH'($signed(cfg_data));
                CFG_MAX_LIMIT:   max_reg    <= POS_WIDTH'($signed(cfg_data));
                CFG_INVERT_DIR:  invert_reg <= cfg_data[0];
                CFG_ENABLE_GATE: gate_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign position        = FIELD_WIDTH'(pos_reg);
    assign target_position = FIELD_WIDTH'(goal_reg);
    assign step_level      = ctrl_reg.step_pin;
    assign dir_level       = dir_reg;
    assign status          = ctrl_reg.status;
    assign moved           = moved_reg;

`include "stepper_position_stepper_with_limits_assert.svh"

    `SPSWL_ASSERT_NOW(a_moved_status, out_valid_reg && moved_reg,
        ctrl_reg.status == ST_MOVING, "step made without moving status")
    `SPSWL_ASSERT_NEXT(a_step_one, advance && moved_next,
        (pos_reg == $past(pos_reg) + POS_WIDTH'(1)) ||
        (pos_reg == $past(pos_reg) - POS_WIDTH'(1)), "step changed position by more than one")
    `SPSWL_ASSERT_NEXT(a_hold_state, out_valid_reg && out_stall,
        $stable(pos_reg) && $stable(goal_reg) && $stable(ctrl_reg),
        "state changed while result stalled")
    `SPSWL_ASSERT_NOW(a_stall_busy, in_stall, in_valid_reg && out_valid_reg,
        "input stalled with room in the pipeline")

endmodule

### rtl/core/spswl_step_unit.sv
// ----------------------------------------------------------------------------
// spswl_step_unit
// Next-state logic for one request: target update, limit checks, one step.
// ----------------------------------------------------------------------------
module spswl_step_unit
    import spswl_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEFAULT
)
(
    input  logic [CMD_WIDTH-1:0]          command,
    input  logic [FIELD_WIDTH-1:0]        new_target,
    input  logic signed [POS_WIDTH-1:0]   pos,
    input  logic signed [POS_WIDTH-1:0]   goal,
    input  ctrl_t                         ctrl,
    input  logic signed [POS_WIDTH-1:0]   min_limit,
    input  logic signed [POS_WIDTH-1:0]   max_limit,
    input  logic                          use_enable_gate,
    output logic signed [POS_WIDTH-1:0]   pos_next,
    output logic signed [POS_WIDTH-1:0]   goal_next,
    output ctrl_t                         ctrl_next,
    output logic                          step_made
);

    localparam logic signed [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    cmd_t                        cmd;
    logic signed [POS_WIDTH-1:0] target_wide;
    logic signed [POS_WIDTH-1:0] pos_base;
    ctrl_t                       ctrl_mid;
    logic                        goal_below;
    logic                        min_lt_pos;
    logic                        pos_lt_max;
    logic                        min_lt_goal;
    logic                        goal_lt_max;
    logic                        step_en;
    logic                        step_up;

    assign cmd         = cmd_t'(command);
    assign target_wide = POS_WIDTH'($signed(new_target));
    assign goal_below  = goal < pos;
    assign min_lt_pos  = min_limit < pos;
    assign pos_lt_max  = pos < max_limit;
    assign min_lt_goal = min_limit < goal;
    assign goal_lt_max = goal < max_limit;

    always_comb
    begin
        goal_next = goal;
        pos_base  = pos;
        ctrl_mid  = ctrl;
        step_en   = 1'b0;
        step_up   = 1'b0;
        unique case (cmd)
            CMD_TICK:
            begin
                if (!(use_enable_gate && !ctrl.enabled))
                begin
                    if (goal == pos)
                    begin
                        ctrl_mid.status = ST_REACHED;
                    end
                    else
                    begin
                        ctrl_mid.heading_back = goal_below;
                        if (min_lt_pos && pos_lt_max)
                        begin
                            step_en = 1'b1;
                            step_up = !goal_below;
                        end
                        else if (pos == min_limit)
                        begin
                            if (min_lt_goal)
                            begin
                                step_en = 1'b1;
                                step_up = 1'b1;
                            end
                            else
                            begin
                                ctrl_mid.status = ST_AT_MIN;
                            end
                        end
                        else if (pos == max_limit)
                        begin
                            if (goal_lt_max)
                            begin
                                step_en = 1'b1;
                                step_up = 1'b0;
                            end
                            else
                            begin
                                ctrl_mid.status = ST_AT_MAX;
                            end
                        end
                    end
                end
            end
            CMD_MOVE_TO:  goal_next = target_wide;
            CMD_GO_MIN:   goal_next = min_limit;
            CMD_GO_MAX:   goal_next = max_limit;
            CMD_GO_ZERO:  goal_next = '0;
            CMD_SET_ZERO:
            begin
                pos_base  = '0;
                goal_next = '0;
            end
            CMD_STOP:     goal_next = pos;
            CMD_ENABLE:   ctrl_mid.enabled = use_enable_gate;
            CMD_DISABLE:  ctrl_mid.enabled = !use_enable_gate;
            default:      ;
        endcase
    end

    // advance the count and toggle the step pin
    always_comb
    begin
        pos_next  = pos_base;
        ctrl_next = ctrl_mid;
        if (step_en)
        begin
            ctrl_next.step_pin   = ctrl.step_phase ? PIN_HIGH : PIN_LOW;
            ctrl_next.step_phase = !ctrl.step_phase;
            ctrl_next.status     = ST_MOVING;
            pos_next             = step_up ? (pos + POS_ONE) : (pos - POS_ONE);
        end
    end

    assign step_made = step_en;

endmodule

### bench/tb_stepper_position_stepper_with_limits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_position_stepper_with_limits
// Self-checking bench for the stepper position controller. A queue of
// commands and ticks feeds a driver with random gaps. A request-level
// motor model predicts every result. A monitor with random stalls compares
// each result field by field against the oldest prediction. The soft limits,
// direction inversion and enable gating are reprogrammed between phases,
// only while the block is idle.
// ----------------------------------------------------------------------------
module tb_stepper_position_stepper_with_limits;
    import spswl_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [CMD_WIDTH-1:0]   cmd;
        logic [FIELD_WIDTH-1:0] target;
    } motor_req_t;

    typedef struct {
        logic [FIELD_WIDTH-1:0] pos;
        logic [FIELD_WIDTH-1:0] tgt;
        logic                   step;
        logic                   dir;
        status_t                st;
        logic                   moved;
    } motion_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [CMD_WIDTH-1:0]          command = CMD_TICK;
    logic signed [FIELD_WIDTH-1:0] new_target = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [FIELD_WIDTH-1:0] position;
    logic signed [FIELD_WIDTH-1:0] target_position;
    logic                          step_level;
    logic                          dir_level;
    logic [1:0]                    status;
    logic                          moved;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [FIELD_WIDTH-1:0]        cfg_data = '0;

    logic signed [FIELD_WIDTH-1:0] pos_q = '0;
    logic signed [FIELD_WIDTH-1:0] goal_q = '0;
    logic signed [FIELD_WIDTH-1:0] lim_lo = '0;
    logic signed [FIELD_WIDTH-1:0] lim_hi = '0;
    logic                          phase_q = 1'b0;
    logic                          pin_q = 1'b0;
    logic                          back_q = 1'b0;
    logic                          en_q = 1'b0;
    logic                          inv_q = 1'b0;
    logic                          gate_q = 1'b0;
    status_t                       status_q = ST_REACHED;

    motor_req_t pending_requests[$];
    motion_t    expected_motion[$];
    int         total_sent = 0;
    int         results_seen = 0;
    int         errors = 0;
    int         cycles = 0;
    int         idle_left = 0;
    int         stall_left = 0;
    int         stall_len = 0;
    bit         quiet_mode = 1'b0;

    stepper_position_stepper_with_limits i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .new_target      (new_target),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position        (position),
        .target_position (target_position),
        .step_level      (step_level),
        .dir_level       (dir_level),
        .status          (status),
        .moved           (moved),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void take_step(input logic up);
        pin_q    = phase_q;
        phase_q  = !phase_q;
        pos_q    = up ? pos_q + 1 : pos_q - 1;
        status_q = ST_MOVING;
    endfunction

    function automatic motion_t advance_motor(input logic [CMD_WIDTH-1:0] code,
                                              input logic signed [FIELD_WIDTH-1:0] tgt);
        motion_t m;
        m.moved = 1'b0;
        case (code)
            CMD_TICK:
            begin
                if (gate_q && !en_q)
                    m.moved = 1'b0;
                else if (goal_q == pos_q)
                    status_q = ST_REACHED;
                else
                begin
                    back_q = goal_q < pos_q;
                    if (lim_lo < pos_q && pos_q < lim_hi)
                    begin
                        take_step(!back_q);
                        m.moved = 1'b1;
                    end
                    else if (pos_q == lim_lo)
                    begin
                        if (lim_lo < goal_q)
                        begin
                            take_step(1'b1);
                            m.moved = 1'b1;
                        end
                        else
                            status_q = ST_AT_MIN;
                    end
                    else if (pos_q == lim_hi)
                    begin
                        if (goal_q < lim_hi)
                        begin
                            take_step(1'b0);
                            m.moved = 1'b1;
                        end
                        else
                            status_q = ST_AT_MAX;
                    end
                end
            end
            CMD_MOVE_TO:  goal_q = tgt;
            CMD_GO_MIN:   goal_q = lim_lo;
            CMD_GO_MAX:   goal_q = lim_hi;
            CMD_GO_ZERO:  goal_q = '0;
            CMD_SET_ZERO:
            begin
                pos_q  = '0;
                goal_q = '0;
            end
            CMD_STOP:     goal_q = pos_q;
            CMD_ENABLE:   en_q = gate_q;
            CMD_DISABLE:  en_q = !gate_q;
            default:      ;
        endcase
        m.pos  = pos_q;
        m.tgt  = goal_q;
        m.step = pin_q;
        m.dir  = back_q ^ inv_q;
        m.st   = status_q;
        return m;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] near_window();
        logic [FIELD_WIDTH-1:0] base;
        case ($urandom_range(0, 2))
            0:       base = lim_lo;
            1:       base = lim_hi;
            default: base = 32'($urandom_range(0, 10)) - 32'd5;
        endcase
        return base + 32'($urandom_range(0, 6)) - 32'd3;
    endfunction

    function automatic motor_req_t random_request();
        motor_req_t r;
        int         roll;
        r.target = $urandom;
        roll     = $urandom_range(0, 99);
        if (roll < 55)
            r.cmd = CMD_TICK;
        else if (roll < 75)
        begin
            r.cmd    = CMD_MOVE_TO;
            r.target = near_window();
        end
        else if (roll < 79)
            r.cmd = CMD_MOVE_TO;
        else if (roll < 81)
        begin
            r.cmd    = CMD_MOVE_TO;
            r.target = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        end
        else if (roll < 91)
            r.cmd = CMD_WIDTH'($urandom_range(CMD_GO_MIN, CMD_STOP));
        else if (roll < 97)
            r.cmd = $urandom_range(0, 1) ? CMD_ENABLE : CMD_DISABLE;
        else
            r.cmd = CMD_WIDTH'($urandom_range(CMD_DISABLE + 1, 2**CMD_WIDTH - 1));
        return r;
    endfunction

    task automatic queue_request(input logic [CMD_WIDTH-1:0] cmd,
                                 input logic [FIELD_WIDTH-1:0] target);
        motor_req_t r;
        r.cmd    = cmd;
        r.target = target;
        pending_requests.push_back(r);
        total_sent++;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (results_seen != total_sent);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [FIELD_WIDTH-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_LIMIT:   lim_lo = data;
            CFG_MAX_LIMIT:   lim_hi = data;
            CFG_INVERT_DIR:  inv_q  = data[0];
            CFG_ENABLE_GATE: gate_q = data[0];
            default:         ;
        endcase
    endtask

    task automatic configure(input logic [FIELD_WIDTH-1:0] lo, input logic [FIELD_WIDTH-1:0] hi,
                             input logic inv, input logic gate);
        write_reg(CFG_MIN_LIMIT, lo);
        write_reg(CFG_MAX_LIMIT, hi);
        write_reg(CFG_INVERT_DIR, ($urandom & ~32'd1) | 32'(inv));
        write_reg(CFG_ENABLE_GATE, ($urandom & ~32'd1) | 32'(gate));
        write_reg(CFG_INDEX_WIDTH'($urandom_range(CFG_ENABLE_GATE + 1,
                                                  2**CFG_INDEX_WIDTH - 1)), $urandom);
    endtask

    task automatic random_phase(input int count, input bit quiet);
        quiet_mode = quiet;
        repeat (count) pending_requests.push_back(random_request());
        total_sent += count;
        settle();
    endtask

    task automatic check_field(input string name, input logic [FIELD_WIDTH-1:0] want,
                               input logic [FIELD_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= CMD_TICK;
            new_target <= '0;
            idle_left  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_motion.push_back(advance_motor(command, new_target));
            if (in_valid && in_stall)
                ;
            else if (idle_left != 0)
            begin
                in_valid  <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                in_valid   <= 1'b1;
                command    <= pending_requests[0].cmd;
                new_target <= pending_requests[0].target;
                idle_left  <= pick_gap();
                void'(pending_requests.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_motion.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual position %0d",
                             $time, position);
                    errors++;
                end
                else
                begin
                    check_field("position", expected_motion[0].pos, position);
                    check_field("target_position", expected_motion[0].tgt, target_position);
                    check_field("step_level", 32'(expected_motion[0].step), 32'(step_level));
                    check_field("dir_level", 32'(expected_motion[0].dir), 32'(dir_level));
                    check_field("status", 32'(expected_motion[0].st), 32'(status));
                    check_field("moved", 32'(expected_motion[0].moved), 32'(moved));
                    void'(expected_motion.pop_front());
                end
                results_seen++;
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                stall_len = pick_gap();
                out_stall  <= (stall_len != 0);
                stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int lo_r;
        int hi_r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        quiet_mode = 1'b0;
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_MOVE_TO, 32'd5);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_MOVE_TO, -32'sd3);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_SET_ZERO, $urandom);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_GO_MAX, $urandom);
        queue_request(CMD_GO_MIN, $urandom);
        queue_request(CMD_MOVE_TO, 32'h7fff_ffff);
        queue_request(CMD_GO_ZERO, $urandom);
        queue_request(CMD_MOVE_TO, 32'h8000_0000);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_STOP, $urandom);
        queue_request(CMD_ENABLE, $urandom);
        queue_request(CMD_DISABLE, $urandom);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_WIDTH'(CMD_DISABLE + 1), $urandom);
        queue_request(CMD_WIDTH'(2**CMD_WIDTH - 1), $urandom);
        queue_request(CMD_MOVE_TO, 32'hffff_ffff);
        queue_request(CMD_TICK, $urandom);
        settle();

        configure(-32'sd4, 32'sd4, 1'b1, 1'b1);
        random_phase(90, 1'b0);

        configure(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0);
        random_phase(70, 1'b1);

        configure(32'sd3, 32'sd3, 1'b1, 1'b0);
        queue_request(CMD_SET_ZERO, $urandom);
        queue_request(CMD_MOVE_TO, 32'sd5);
        queue_request(CMD_TICK, $urandom);
        queue_request(CMD_MOVE_TO, -32'sd2);
        queue_request(CMD_TICK, $urandom);
        settle();
        random_phase(40, 1'b0);

        configure(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1);
        random_phase(30, 1'b0);

        repeat (4)
        begin
            lo_r = $urandom_range(0, 16) - 8;
            hi_r = lo_r + $urandom_range(0, 14) - 2;
            configure(lo_r, hi_r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            random_phase(60, $urandom_range(0, 3) == 0);
        end

        if (expected_motion.size() != 0)
        begin
            $display("%0t missing results: expected %0d more, actual none",
                     $time, expected_motion.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spswl_pkg.sv
rtl/core/spswl_step_unit.sv
rtl/core/stepper_position_stepper_with_limits.sv
bench/tb_stepper_position_stepper_with_limits.sv
